/* src/hcr_pkg.sv */
// Shared types, widths and helpers for the half circle rasterizer.
package hcr_pkg;

	localparam int IN_W   = 10; // rectangle coordinate field width
	localparam int OUT_W  = 12; // result coordinate field width
	localparam int RAD_W  = 5;  // radius width, covers the largest legal radius
	localparam int STEP_W = 7;  // step counters, signed room for one below zero
	localparam int ERR_W  = 12; // error term and its intermediate products
	localparam int CNT_W  = 6;  // result counter within one rectangle

	typedef struct packed {
		logic [IN_W-1:0] left_x;
		logic [IN_W-1:0] bottom_y;
		logic [IN_W-1:0] right_x;
		logic [IN_W-1:0] top_y;
		logic            flip;
	} rect_t;

	typedef struct packed {
		logic signed [OUT_W-1:0] x_right;
		logic signed [OUT_W-1:0] x_left;
		logic signed [OUT_W-1:0] y_out;
		logic                    last;
	} pt_t;

	// Classified rectangle handed from the front end to the scan engine
	typedef struct packed {
		logic [IN_W-1:0]  centre_x;
		logic [IN_W-1:0]  base_y;
		logic [RAD_W-1:0] rad;
		logic             flipped;
	} job_t;

	// Queue status seen by both sides
	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	// floor(v / 10) via reciprocal multiply, exact for every 8-bit v
	function automatic logic [4:0] div10(input logic [7:0] v);
		logic [15:0] p;
		p = {8'd0, v} * 16'd205;
		return p[15:11];
	endfunction

endpackage

/* src/hcr_front.sv */
// Front end: masks coordinates, derives centre, radius and base row, drops empty requests.
module hcr_front
	import hcr_pkg::*;
#(
	parameter int MAX_RADIUS = 31,
	parameter int COORD_BITS = 10
) (
	input  rect_t   rect,
	input  logic    rect_valid,
	output logic    rect_ready,
	input  q_stat_t qs,
	output logic    push,
	output job_t    job
);

	localparam int CW = (COORD_BITS < IN_W) ? COORD_BITS : IN_W;
	localparam logic [IN_W-1:0] CMASK = {IN_W{1'b1}} >> (IN_W - CW);
	localparam logic [IN_W-2:0] RMAX  = (IN_W-1)'(MAX_RADIUS);

	logic [IN_W-1:0]        lx, rx, by, ty;
	logic [IN_W:0]          sum;
	logic signed [IN_W:0]   diff;
	logic [IN_W-2:0]        mag;
	logic                   drop;

	// Mask inputs and classify the rectangle
	always_comb begin
		lx   = rect.left_x & CMASK;
		rx   = rect.right_x & CMASK;
		by   = rect.bottom_y & CMASK;
		ty   = rect.top_y & CMASK;
		sum  = {1'b0, lx} + {1'b0, rx};
		diff = $signed({1'b0, rx}) - $signed({1'b0, lx});
		mag  = diff[IN_W-1:1];
		// a difference of minus one still truncates to radius zero
		drop = diff[IN_W] && (diff != {(IN_W+1){1'b1}});

		job.centre_x = sum[IN_W:1];
		job.base_y   = rect.flip ? ty : by;
		job.flipped  = rect.flip;
		if (diff[IN_W]) begin
			job.rad = '0;
		end else if (mag > RMAX) begin
			job.rad = RAD_W'(MAX_RADIUS);
		end else begin
			job.rad = mag[RAD_W-1:0];
		end
	end

	assign rect_ready = !qs.full;
	assign push       = rect_valid && !qs.full && !drop;

endmodule

/* src/hcr_queue.sv */
// Two-entry queue between the front end and the scan engine.
module hcr_queue
	import hcr_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  job_t    wr_job,
	input  logic    pop,
	output job_t    rd_job,
	output q_stat_t qs
);

	job_t       slot_q [2];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] cnt_q;

	// Store pushed requests
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= wr_job;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= !wr_ptr_q;
			if (pop)  rd_ptr_q <= !rd_ptr_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	assign rd_job   = slot_q[rd_ptr_q];
	assign qs.full  = cnt_q == 2'd2;
	assign qs.empty = cnt_q == 2'd0;

endmodule

/* src/hcr_back.sv */
// Scan engine: runs the midpoint circle recurrence and emits one point pair per cycle while the output does not stall.
module hcr_back
	import hcr_pkg::*;
#(
	parameter int MAX_RADIUS = 31
) (
	input  logic    clk,
	input  logic    arst_n,
	input  q_stat_t qs,
	input  job_t    job,
	output logic    pop,
	output pt_t     pt,
	output logic    pt_valid,
	input  logic    pt_ready
);

	localparam logic [CNT_W-1:0] LAST_N = CNT_W'(2 * MAX_RADIUS + 1);

	typedef enum logic {IDLE, RUN} state_t;

	state_t                   state_q;
	job_t                     job_q;
	logic [STEP_W-1:0]        x_q;
	logic signed [STEP_W-1:0] y_q;
	logic signed [ERR_W-1:0]  d_q;
	logic [CNT_W-1:0]         n_q;
	pt_t                      pt_q;
	logic                     pt_valid_q;

	logic                     fire, last_pt;
	logic signed [ERR_W-1:0]  xe, ye, e1, e2, d_n;
	logic [STEP_W-1:0]        x_n;
	logic signed [STEP_W-1:0] y_n;
	logic [7:0]               v7;
	logic [OUT_W-1:0]         cx, by, sq;
	pt_t                      pt_n;

	// Next step of the error recurrence
	always_comb begin
		xe = ERR_W'($signed({1'b0, x_q}));
		ye = ERR_W'(y_q);
		e1 = ERR_W'(2 * (d_q + ye) - 1);
		e2 = ERR_W'(2 * (d_q - xe) - 1);
		priority if (d_q < 0 && e1 <= 0) begin
			x_n = x_q + 1'b1;
			y_n = y_q;
			d_n = ERR_W'(d_q + 2 * xe + 3);
		end else if (d_q > 0 && e2 > 0) begin
			x_n = x_q;
			y_n = y_q - 1'b1;
			d_n = ERR_W'(d_q + 3 - 2 * ye);
		end else begin
			x_n = x_q + 1'b1;
			y_n = y_q - 1'b1;
			d_n = ERR_W'(d_q + 2 * (xe - ye) + 2);
		end
		last_pt = y_n[STEP_W-1] || (n_q == LAST_N);
	end

	// Form the point pair for the current step
	always_comb begin
		v7 = {3'b000, y_q[RAD_W-1:0]} * 8'd7;
		cx = OUT_W'(job_q.centre_x);
		by = OUT_W'(job_q.base_y);
		if (job_q.flipped) begin
			sq = by - OUT_W'(div10(v7 + 8'd9));
		end else begin
			sq = by + OUT_W'(div10(v7));
		end
		pt_n.x_right = cx + OUT_W'(x_q);
		pt_n.x_left  = cx - OUT_W'(x_q);
		pt_n.y_out   = sq;
		pt_n.last    = last_pt;
	end

	assign fire = (state_q == RUN) && (!pt_valid_q || pt_ready);
	assign pop  = (state_q == IDLE) && !qs.empty;

	// Sequencer, recurrence registers and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= IDLE;
			pt_valid_q <= 1'b0;
			job_q      <= '0;
			x_q        <= '0;
			y_q        <= '0;
			d_q        <= '0;
			n_q        <= '0;
			pt_q       <= '0;
		end else begin
			unique case (state_q)
				IDLE: begin
					if (pop) begin
						job_q   <= job;
						x_q     <= '0;
						y_q     <= STEP_W'(job.rad);
						d_q     <= ERR_W'(2 - 2 * int'(job.rad));
						n_q     <= '0;
						state_q <= RUN;
					end
				end
				RUN: begin
					if (fire) begin
						x_q <= x_n;
						y_q <= y_n;
						d_q <= d_n;
						n_q <= n_q + 1'b1;
						if (last_pt) state_q <= IDLE;
					end
				end
				default: state_q <= IDLE;
			endcase

			// hold the point until taken
			if (fire) begin
				pt_q       <= pt_n;
				pt_valid_q <= 1'b1;
			end else if (pt_ready) begin
				pt_valid_q <= 1'b0;
			end
		end
	end

	assign pt       = pt_q;
	assign pt_valid = pt_valid_q;

endmodule

/* src/half_circle_rasterizer.sv */
// Top level of the half circle rasterizer: front end, queue and scan engine.
//
//  channel   direction  handshake                 payload
//  rect      in         rect_valid / rect_ready   rect  (rect_t)
//  pt        out        pt_valid / pt_ready       pt    (pt_t)
//
// A rectangle of radius r yields up to 2*r+2 point pairs, one per cycle while the pt channel
// does not stall; the scan engine first loads the rectangle from the queue in its IDLE state.
// The two-entry queue takes new requests while the engine is busy; requests with
// a negative radius are accepted and dropped. Reset clears all control state.
// A stalled pt channel holds the engine; the rect side stalls only when the queue is full.
module half_circle_rasterizer
	import hcr_pkg::*;
#(
	parameter int MAX_RADIUS = 31,
	parameter int COORD_BITS = 10
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  rect_valid,
	output logic  rect_ready,
	input  rect_t rect,
	output logic  pt_valid,
	input  logic  pt_ready,
	output pt_t   pt
);

	q_stat_t qs;
	logic    push, pop;
	job_t    wr_job, rd_job;

	hcr_front #(
		.MAX_RADIUS(MAX_RADIUS),
		.COORD_BITS(COORD_BITS)
	) u_front (
		.rect      (rect),
		.rect_valid(rect_valid),
		.rect_ready(rect_ready),
		.qs        (qs),
		.push      (push),
		.job       (wr_job)
	);

	hcr_queue u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.wr_job(wr_job),
		.pop   (pop),
		.rd_job(rd_job),
		.qs    (qs)
	);

	hcr_back #(
		.MAX_RADIUS(MAX_RADIUS)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.qs      (qs),
		.job     (rd_job),
		.pop     (pop),
		.pt      (pt),
		.pt_valid(pt_valid),
		.pt_ready(pt_ready)
	);

	// Mirrored points sit an even distance apart
	a_mirror_even: assert property (@(posedge clk) disable iff (!arst_n)
		pt_valid |-> ((pt.x_right - pt.x_left) & 12'sd1) == 12'sd0)
		else $error("mirrored points not symmetric about the centre");

	// The queue never pushes when full nor pops when empty
	a_queue_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && qs.full) && !(pop && qs.empty))
		else $error("queue overflow or underflow");

	// Input ready drops only when the queue is full
	a_ready_full: assert property (@(posedge clk) disable iff (!arst_n)
		!rect_ready |-> qs.full)
		else $error("request stalled with queue space free");

endmodule

/* dv/tb.sv */
// Testbench for the half circle rasterizer: random and directed rectangles, point checking.
`timescale 1ns / 1ps

module tb;
	import hcr_pkg::*;

	localparam int MAX_RAD     = 31;
	localparam int POINT_CAP   = 2 * MAX_RAD + 2;
	localparam int DRAIN_WAIT  = 70;   // settle time for stray points after the last expected one
	localparam int IDLE_LIMIT  = 4000; // cycles with no request moving on either side
	localparam int HOLD_CYCLES = 400;  // long receiver hold-off
	localparam int RANDOM_RECTS = 480;

	typedef enum {RX_OPEN, RX_HALF, RX_MOSTLY, RX_SPARSE} rx_mode_e;

	logic  clk = 1'b0;
	logic  arst_n = 1'b0;
	logic  rect_valid = 1'b0;
	logic  rect_ready;
	rect_t rect = '0;
	logic  pt_valid;
	logic  pt_ready = 1'b0;
	pt_t   pt;

	pt_t expected_pts[$];
	int  mismatches = 0;
	int  rects_sent = 0;
	int  empty_rects = 0;
	int  wide_rects = 0;
	int  pts_checked = 0;
	int  burst_left = 0;
	int  idle_cycles = 0;
	bit  hold_req = 1'b0;

	half_circle_rasterizer uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.rect_valid (rect_valid),
		.rect_ready (rect_ready),
		.rect       (rect),
		.pt_valid   (pt_valid),
		.pt_ready   (pt_ready),
		.pt         (pt)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	// Queue the point pairs one rectangle must produce, in scan order
	function automatic void predict_arc(input rect_t r);
		int lx, rx, cx, base, rad, sx, sy, delta, e, sq, n;
		pt_t p;
		lx   = int'(r.left_x);
		rx   = int'(r.right_x);
		cx   = (lx + rx) / 2;
		base = r.flip ? int'(r.top_y) : int'(r.bottom_y);
		rad  = (rx - lx) / 2;
		if (rad > MAX_RAD) begin
			rad = MAX_RAD;
			wide_rects++;
		end
		if (rad < 0) begin
			empty_rects++;
			return;
		end
		sx = 0;
		sy = rad;
		delta = 2 - 2 * rad;
		n = 0;
		while (sy >= 0 && n < POINT_CAP) begin
			// squash y by 0.7: floor going up, ceiling going down
			sq = r.flip ? base - (7 * sy + 9) / 10 : base + (7 * sy) / 10;
			p.x_right = OUT_W'(cx + sx);
			p.x_left  = OUT_W'(cx - sx);
			p.y_out   = OUT_W'(sq);
			// advance the midpoint error recurrence
			e = 2 * (delta + sy) - 1;
			if (delta < 0 && e <= 0) begin
				sx++;
				delta += 2 * sx + 1;
			end else begin
				e = 2 * (delta - sx) - 1;
				if (delta > 0 && e > 0) begin
					sy--;
					delta += 1 - 2 * sy;
				end else begin
					sx++;
					delta += 2 * (sx - sy);
					sy--;
				end
			end
			n++;
			p.last = (sy < 0) || (n == POINT_CAP);
			expected_pts.push_back(p);
		end
	endfunction

	function automatic rect_t make_rect(input int lx, input int by, input int rx, input int ty,
		input bit fl);
		rect_t r;
		r.left_x   = IN_W'(lx);
		r.bottom_y = IN_W'(by);
		r.right_x  = IN_W'(rx);
		r.top_y    = IN_W'(ty);
		r.flip     = fl;
		return r;
	endfunction

	// Offer one rectangle, idling between bursts, and wait for its request to go through
	task automatic send_rect(input rect_t r);
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(1, 10);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
				: $urandom_range(1, 12);
			rect_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		burst_left--;
		rect_valid <= 1'b1;
		rect <= r;
		do @(posedge clk); while (!rect_ready);
		predict_arc(r);
		rects_sent++;
	endtask

	function automatic int edge_biased_y();
		case ($urandom_range(0, 7))
			0: return $urandom_range(0, 30);
			1: return $urandom_range(1000, 1023);
			default: return $urandom_range(0, 1023);
		endcase
	endfunction

	function automatic rect_t random_rect();
		int kind, d, lx, rx;
		kind = $urandom_range(0, 9);
		if (kind >= 8) begin
			lx = $urandom_range(0, 1023);
			rx = $urandom_range(0, 1023);
		end else begin
			if (kind <= 5)
				d = $urandom_range(0, 66);
			else if (kind == 6)
				d = -$urandom_range(1, 40);
			else
				d = $urandom_range(0, 3) - 1;
			lx = (d >= 0) ? $urandom_range(0, 1023 - d) : $urandom_range(-d, 1023);
			rx = lx + d;
		end
		return make_rect(lx, edge_biased_y(), rx, edge_biased_y(), $urandom_range(0, 1));
	endfunction

	// Full-range edges: zero and full width, arcs wrapping past both ends of y
	task automatic test_coord_extremes();
		send_rect(make_rect(0, 0, 0, 0, 1'b0));
		send_rect(make_rect(0, 0, 0, 0, 1'b1));
		send_rect(make_rect(1023, 1023, 1023, 1023, 1'b0));
		send_rect(make_rect(1023, 1023, 1023, 1023, 1'b1));
		send_rect(make_rect(0, 1023, 1023, 0, 1'b0));
		send_rect(make_rect(0, 1023, 1023, 0, 1'b1));
		send_rect(make_rect(0, 0, 1023, 1023, 1'b1));
	endtask

	// Right edge left of the left edge: dropped, except a difference of one; also a width of one
	task automatic test_reversed_edges();
		send_rect(make_rect(1023, 512, 0, 512, 1'b0));
		send_rect(make_rect(5, 100, 4, 200, 1'b0));
		send_rect(make_rect(5, 100, 4, 200, 1'b1));
		send_rect(make_rect(600, 300, 598, 300, 1'b1));
		send_rect(make_rect(0, 300, 1, 300, 1'b0));
	endtask

	// Small radii, the largest legal radius and saturation just past it
	task automatic test_radius_sweep();
		send_rect(make_rect(500, 400, 502, 600, 1'b0));
		send_rect(make_rect(500, 400, 505, 600, 1'b1));
		send_rect(make_rect(200, 40, 220, 60, 1'b0));
		send_rect(make_rect(200, 40, 262, 60, 1'b1));
		send_rect(make_rect(201, 40, 264, 60, 1'b0));
		send_rect(make_rect(300, 700, 364, 900, 1'b1));
		send_rect(make_rect(300, 700, 365, 900, 1'b0));
	endtask

	// Stall the point side for a long stretch while rectangles keep coming
	task automatic test_backpressure();
		hold_req = 1'b1;
		burst_left = 14;
		repeat (12)
			send_rect(make_rect(100, edge_biased_y(), 100 + $urandom_range(40, 66),
				edge_biased_y(), $urandom_range(0, 1)));
	endtask

	task automatic test_random_rects();
		repeat (RANDOM_RECTS)
			send_rect(random_rect());
	endtask

	// Point receiver: long hold-off on request, otherwise a changing stall pattern
	initial begin : pt_receiver
		rx_mode_e mode;
		int       mode_left;
		int       hold_left;
		mode = RX_OPEN;
		mode_left = 0;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				pt_ready <= 1'b0;
			end else begin
				if (mode_left == 0) begin
					mode = rx_mode_e'($urandom_range(0, 3));
					mode_left = $urandom_range(20, 200);
				end
				mode_left--;
				case (mode)
					RX_OPEN:   pt_ready <= 1'b1;
					RX_HALF:   pt_ready <= $urandom_range(0, 1);
					RX_MOSTLY: pt_ready <= ($urandom_range(0, 3) != 0);
					default:   pt_ready <= ($urandom_range(0, 3) == 0);
				endcase
			end
		end
	end

	task automatic check_field(input string name, input logic signed [OUT_W-1:0] want,
		input logic signed [OUT_W-1:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
			mismatches++;
		end
	endtask

	// Compare every accepted point pair with the oldest pending one
	always @(posedge clk) begin : pt_monitor
		pt_t want;
		if (arst_n && pt_valid && pt_ready) begin
			if (expected_pts.size() == 0) begin
				$display("%0t: unexpected point x_right=%0d x_left=%0d y=%0d last=%0b",
					$time, pt.x_right, pt.x_left, pt.y_out, pt.last);
				mismatches++;
			end else begin
				want = expected_pts.pop_front();
				check_field("x_right", want.x_right, pt.x_right);
				check_field("x_left", want.x_left, pt.x_left);
				check_field("y_out", want.y_out, pt.y_out);
				check_field("last", OUT_W'(want.last), OUT_W'(pt.last));
				pts_checked++;
			end
		end
	end

	// Drop the run if no request moves for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((rect_valid && rect_ready) || (pt_valid && pt_ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("%0t: no progress for %0d cycles, %0d points pending", $time,
					idle_cycles, expected_pts.size());
				$display("[half_circle_rasterizer] ERROR");
				$finish;
			end
		end
	end

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_coord_extremes();
		test_reversed_edges();
		test_radius_sweep();
		test_backpressure();
		test_random_rects();
		rect_valid <= 1'b0;
		// drain, then watch for stray points
		while (expected_pts.size() != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		$display("covered %0d rectangles (%0d empty, %0d with clamped radius)",
			rects_sent, empty_rects, wide_rects);
		$display("checked %0d point pairs under random gaps, stalls and a long hold-off",
			pts_checked);
		if (mismatches == 0 && expected_pts.size() == 0)
			$display("[half_circle_rasterizer] OK");
		else
			$display("[half_circle_rasterizer] ERROR");
		$finish;
	end

endmodule

/* sim.f */
src/hcr_pkg.sv
src/hcr_front.sv
src/hcr_queue.sv
src/hcr_back.sv
src/half_circle_rasterizer.sv
dv/tb.sv
